// ===== design/bfg_pkg.sv =====
package bfg_pkg;

    // image and window limits
    localparam int MAX_WIDTH        = 1024;
    localparam int MAX_HEIGHT       = 1024;
    localparam int MAX_RADIUS       = 3;
    localparam int WEIGHT_FRAC_BITS = 16;

    // field widths
    localparam int PIX_W = 8;
    localparam int COL_W = 10;
    localparam int ROW_W = 10;
    localparam int CFG_W = 11;
    localparam int RAD_W = 2;
    localparam int IDX_W = 8;
    localparam int WT_W  = 17;
    localparam int CFG_IDX_W = 2;

    // line store geometry: a power-of-two ring of rows
    // on narrow images the input runs up to 2R rows ahead of the output row
    localparam int LINE_ROWS = 2 ** $clog2(3 * MAX_RADIUS + 1);
    localparam int LROW_W    = $clog2(LINE_ROWS);
    localparam int LADDR_W   = LROW_W + COL_W;
    localparam int POS_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    // window geometry
    localparam int WIN_SIDE  = 2 * MAX_RADIUS + 1;
    localparam int OFF_W     = $clog2(WIN_SIDE);
    localparam int SP_DEPTH  = MAX_RADIUS * MAX_RADIUS + 1;
    localparam int SP_IDX_W  = $clog2(SP_DEPTH);
    localparam int D2_W      = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int RANGE_DEPTH = 256;

    // accumulator and divider widths
    localparam int WP_W   = WT_W + PIX_W;
    localparam int WSUM_W = WT_W + $clog2(WIN_SIDE * WIN_SIDE);
    localparam int PSUM_W = WSUM_W + PIX_W;
    localparam int NUM_W  = PSUM_W + 1;
    localparam int QUO_W  = PIX_W + 1;
    localparam int DCNT_W = $clog2(QUO_W + 1);

    localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(1 << WEIGHT_FRAC_BITS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_DRAIN   = 2'd1,
        OP_RANGE   = 2'd2,
        OP_SPATIAL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTR,
        ST_WIN,
        ST_FLUSH,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] table_index;
        logic [WT_W-1:0]  weight;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             out_last;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numer;
        logic [WSUM_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // saturate a written weight to 1.0
    function automatic logic [WT_W-1:0] sat_weight(input logic [WT_W-1:0] v);
        logic [WT_W-1:0] r;
        r = (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
        return r;
    endfunction

endpackage

// ===== design/bilateral_filter_gray.sv =====
// Grayscale bilateral filter on a raster pixel stream. Pixels, drain ticks and
// weight-table writes share one input channel; a result for pixel i-L appears
// after pixel i (L = radius rows plus radius columns), and drain ticks push out
// the remaining results once the frame is in. Table writes and items with no
// result do not stall the input. An item with a result holds off the next item
// until its result is loaded into the output register, including any wait on the
// result side: the window is read one tap per cycle from the single-port line
// store, the weight pipeline drains, then, unless the weight sum is zero, a
// 9-bit serial divider forms the mean.
// Register writes restart the frame; weight tables reset to zero.
module bilateral_filter_gray (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bfg_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bfg_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfg_pkg::CFG_W-1:0]         cfg_data
);

    bfg_pkg::state_t state_reg, state_next;

    logic [bfg_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [bfg_pkg::RAD_W-1:0] radius_reg;
    logic [bfg_pkg::CFG_W-1:0] w_used, h_used;
    logic [bfg_pkg::COL_W-1:0] wm1;
    logic [bfg_pkg::POS_W-1:0] total, lag;

    logic [bfg_pkg::POS_W-1:0]  in_pos_reg, out_pos_reg;
    logic [bfg_pkg::LROW_W-1:0] in_row_reg;
    logic [bfg_pkg::COL_W-1:0]  in_col_reg, out_col_reg;
    logic [bfg_pkg::ROW_W-1:0]  out_row_reg;
    logic                       in_done;

    logic [bfg_pkg::OFF_W-1:0] iy_reg, ix_reg, side;
    logic                      cap_reg;
    logic [bfg_pkg::PIX_W-1:0] centre_reg;

    logic [bfg_pkg::WT_W-1:0] sp_reg [bfg_pkg::SP_DEPTH];

    logic                            p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic [bfg_pkg::D2_W-1:0]        p1_d2_reg;
    logic [bfg_pkg::PIX_W-1:0]       p2_p_reg, p3_p_reg;
    logic [bfg_pkg::WT_W-1:0]        p2_s_reg, p3_wt_reg, p4_wt_reg;
    logic [bfg_pkg::WP_W-1:0]        p4_wp_reg;
    logic [bfg_pkg::PSUM_W-1:0]      psum_reg;
    logic [bfg_pkg::WSUM_W-1:0]      wsum_reg;
    logic [bfg_pkg::PIX_W-1:0]       res_reg;

    logic                            m_valid_reg;
    bfg_pkg::out_item_t              m_data_reg;

    logic                            accept, cfg_wr, line_we, range_we, emit_go, out_load;
    logic [bfg_pkg::LADDR_W-1:0]     line_addr;
    logic [bfg_pkg::PIX_W-1:0]       line_q, diff;
    logic [bfg_pkg::WT_W-1:0]        range_q, sp_sel;
    logic signed [bfg_pkg::OFF_W:0]  dy_s, dx_s;
    logic [bfg_pkg::OFF_W-1:0]       ady, adx;
    logic [bfg_pkg::D2_W-1:0]        d2, r2;
    logic signed [bfg_pkg::COL_W+1:0] xs, ys;
    logic [bfg_pkg::COL_W-1:0]       x_cl;
    logic [bfg_pkg::ROW_W-1:0]       y_cl;
    logic [2*bfg_pkg::WT_W-1:0]      sg_prod;
    logic                            pipe_busy, last_tap;

    bfg_pkg::div_req_t div_req;
    bfg_pkg::div_rsp_t div_rsp;

    // used configuration and frame sizes
    always_comb begin
        w_used = (width_reg == '0) ? bfg_pkg::CFG_W'(1)
               : (width_reg > bfg_pkg::CFG_W'(bfg_pkg::MAX_WIDTH))
                 ? bfg_pkg::CFG_W'(bfg_pkg::MAX_WIDTH) : width_reg;
        h_used = (height_reg == '0) ? bfg_pkg::CFG_W'(1)
               : (height_reg > bfg_pkg::CFG_W'(bfg_pkg::MAX_HEIGHT))
                 ? bfg_pkg::CFG_W'(bfg_pkg::MAX_HEIGHT) : height_reg;
    end

    assign wm1     = bfg_pkg::COL_W'(w_used - 1'b1);
    assign total   = bfg_pkg::POS_W'(w_used) * bfg_pkg::POS_W'(h_used);
    assign lag     = bfg_pkg::POS_W'(radius_reg) * bfg_pkg::POS_W'(w_used)
                   + bfg_pkg::POS_W'(radius_reg);
    assign in_done = in_pos_reg >= total;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && (cfg_index == bfg_pkg::REG_IMAGE_WIDTH ||
                                     cfg_index == bfg_pkg::REG_IMAGE_HEIGHT ||
                                     cfg_index == bfg_pkg::REG_RADIUS);
    assign line_we   = accept && s_data.op == bfg_pkg::OP_PIXEL && !in_done;
    assign range_we  = accept && s_data.op == bfg_pkg::OP_RANGE;
    assign emit_go   = accept && ((s_data.op == bfg_pkg::OP_PIXEL && !in_done && in_pos_reg >= lag)
                              || (s_data.op == bfg_pkg::OP_DRAIN && in_done));

    // window tap geometry
    always_comb begin
        side = bfg_pkg::OFF_W'({radius_reg, 1'b0});
        dy_s = $signed({1'b0, iy_reg}) - $signed({{(bfg_pkg::OFF_W+1-bfg_pkg::RAD_W){1'b0}}, radius_reg});
        dx_s = $signed({1'b0, ix_reg}) - $signed({{(bfg_pkg::OFF_W+1-bfg_pkg::RAD_W){1'b0}}, radius_reg});
        ady  = (dy_s < 0) ? bfg_pkg::OFF_W'(-dy_s) : bfg_pkg::OFF_W'(dy_s);
        adx  = (dx_s < 0) ? bfg_pkg::OFF_W'(-dx_s) : bfg_pkg::OFF_W'(dx_s);
        d2   = bfg_pkg::D2_W'(ady) * bfg_pkg::D2_W'(ady)
             + bfg_pkg::D2_W'(adx) * bfg_pkg::D2_W'(adx);
        r2   = bfg_pkg::D2_W'(radius_reg) * bfg_pkg::D2_W'(radius_reg);
        xs   = $signed({2'b00, out_col_reg}) + (bfg_pkg::COL_W+2)'(dx_s);
        ys   = $signed({2'b00, out_row_reg}) + (bfg_pkg::COL_W+2)'(dy_s);
        x_cl = (xs < 0) ? '0 : (xs > $signed({2'b00, wm1})) ? wm1 : xs[bfg_pkg::COL_W-1:0];
        y_cl = (ys < 0) ? '0
             : (ys > $signed({2'b00, bfg_pkg::ROW_W'(h_used - 1'b1)}))
               ? bfg_pkg::ROW_W'(h_used - 1'b1) : ys[bfg_pkg::ROW_W-1:0];
        last_tap = (iy_reg == side) && (ix_reg == side);
    end

    // line store address
    always_comb begin
        unique case (state_reg)
            bfg_pkg::ST_CTR: line_addr = {out_row_reg[bfg_pkg::LROW_W-1:0], out_col_reg};
            bfg_pkg::ST_WIN: line_addr = {y_cl[bfg_pkg::LROW_W-1:0], x_cl};
            default:         line_addr = {in_row_reg, in_col_reg};
        endcase
    end

    bfg_line_mem u_line (
        .aclk  (aclk),
        .we    (line_we),
        .addr  (line_addr),
        .wdata (s_data.pixel),
        .rdata (line_q)
    );

    assign diff = (line_q >= centre_reg) ? line_q - centre_reg : centre_reg - line_q;

    bfg_range_mem u_range (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (range_we),
        .waddr   (s_data.table_index),
        .wdata   (bfg_pkg::sat_weight(s_data.weight)),
        .raddr   (diff),
        .rdata   (range_q)
    );

    assign sp_sel  = (p1_d2_reg < bfg_pkg::D2_W'(bfg_pkg::SP_DEPTH))
                     ? sp_reg[p1_d2_reg[bfg_pkg::SP_IDX_W-1:0]] : '0;
    assign sg_prod = p2_s_reg * range_q;
    assign pipe_busy = p1_valid_reg || p2_valid_reg || p3_valid_reg || p4_valid_reg;

    assign div_req.start = (state_reg == bfg_pkg::ST_FLUSH) && !pipe_busy && (wsum_reg != '0);
    assign div_req.numer = bfg_pkg::NUM_W'(psum_reg) + bfg_pkg::NUM_W'(wsum_reg >> 1);
    assign div_req.denom = wsum_reg;

    bfg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            bfg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (emit_go) begin
                    state_next = bfg_pkg::ST_CTR;
                end
            end
            bfg_pkg::ST_CTR: state_next = bfg_pkg::ST_WIN;
            bfg_pkg::ST_WIN: begin
                if (last_tap) begin
                    state_next = bfg_pkg::ST_FLUSH;
                end
            end
            bfg_pkg::ST_FLUSH: begin
                if (!pipe_busy) begin
                    state_next = (wsum_reg != '0) ? bfg_pkg::ST_DIV : bfg_pkg::ST_OUT;
                end
            end
            bfg_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = bfg_pkg::ST_OUT;
                end
            end
            bfg_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = bfg_pkg::ST_IDLE;
                end
            end
            default: state_next = bfg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration, positions and spatial table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= bfg_pkg::CFG_W'(1024);
            height_reg  <= bfg_pkg::CFG_W'(1024);
            radius_reg  <= bfg_pkg::RAD_W'(1);
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            for (int k = 0; k < bfg_pkg::SP_DEPTH; k++) begin
                sp_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index)
                    bfg_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    bfg_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:                   radius_reg <= cfg_data[bfg_pkg::RAD_W-1:0];
                endcase
                in_pos_reg  <= '0;
                out_pos_reg <= '0;
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
            end else begin
                if (accept && s_data.op == bfg_pkg::OP_SPATIAL &&
                    s_data.table_index < bfg_pkg::IDX_W'(bfg_pkg::SP_DEPTH)) begin
                    sp_reg[s_data.table_index[bfg_pkg::SP_IDX_W-1:0]] <=
                        bfg_pkg::sat_weight(s_data.weight);
                end
                if (line_we) begin
                    in_pos_reg <= in_pos_reg + 1'b1;
                    if (in_col_reg == wm1) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 1'b1;
                    end else begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (out_load) begin
                    if (out_pos_reg + 1'b1 >= total) begin
                        in_pos_reg  <= '0;
                        out_pos_reg <= '0;
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                    end else begin
                        out_pos_reg <= out_pos_reg + 1'b1;
                        if (out_col_reg == wm1) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end else begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // tap counters and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iy_reg       <= '0;
            ix_reg       <= '0;
            cap_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else begin
            cap_reg      <= state_reg == bfg_pkg::ST_CTR;
            p1_valid_reg <= (state_reg == bfg_pkg::ST_WIN) && (d2 <= r2);
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            if (state_reg == bfg_pkg::ST_CTR) begin
                iy_reg <= '0;
                ix_reg <= '0;
            end else if (state_reg == bfg_pkg::ST_WIN) begin
                if (ix_reg == side) begin
                    ix_reg <= '0;
                    iy_reg <= iy_reg + 1'b1;
                end else begin
                    ix_reg <= ix_reg + 1'b1;
                end
            end
        end
    end

    // weight datapath and accumulation
    always_ff @(posedge aclk) begin
        if (cap_reg) begin
            centre_reg <= line_q;
        end
        p1_d2_reg <= d2;
        p2_p_reg  <= line_q;
        p2_s_reg  <= sp_sel;
        p3_p_reg  <= p2_p_reg;
        p3_wt_reg <= sg_prod[bfg_pkg::WEIGHT_FRAC_BITS +: bfg_pkg::WT_W];
        p4_wt_reg <= p3_wt_reg;
        p4_wp_reg <= p3_wt_reg * p3_p_reg;
        if (state_reg == bfg_pkg::ST_CTR) begin
            psum_reg <= '0;
            wsum_reg <= '0;
        end else if (p4_valid_reg) begin
            psum_reg <= psum_reg + bfg_pkg::PSUM_W'(p4_wp_reg);
            wsum_reg <= wsum_reg + bfg_pkg::WSUM_W'(p4_wt_reg);
        end
        if (state_reg == bfg_pkg::ST_FLUSH && !pipe_busy && wsum_reg == '0) begin
            res_reg <= centre_reg;
        end else if (state_reg == bfg_pkg::ST_DIV && div_rsp.done) begin
            res_reg <= div_rsp.quotient[bfg_pkg::QUO_W-1] ? '1
                       : div_rsp.quotient[bfg_pkg::PIX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.out_pixel <= res_reg;
            m_data_reg.out_row   <= out_row_reg;
            m_data_reg.out_col   <= out_col_reg;
            m_data_reg.out_last  <= out_pos_reg == total - 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/bfg_line_mem.sv =====
module bfg_line_mem (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [bfg_pkg::LADDR_W-1:0]   addr,
    input  logic [bfg_pkg::PIX_W-1:0]     wdata,
    output logic [bfg_pkg::PIX_W-1:0]     rdata
);

    localparam int DEPTH = 1 << bfg_pkg::LADDR_W;

    logic [bfg_pkg::PIX_W-1:0] mem [DEPTH];
    logic [bfg_pkg::PIX_W-1:0] rdata_reg;

    // single port ring of image rows
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bfg_range_mem.sv =====
module bfg_range_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        we,
    input  logic [bfg_pkg::IDX_W-1:0]   waddr,
    input  logic [bfg_pkg::WT_W-1:0]    wdata,
    input  logic [bfg_pkg::IDX_W-1:0]   raddr,
    output logic [bfg_pkg::WT_W-1:0]    rdata
);

    logic [bfg_pkg::WT_W-1:0]            mem [bfg_pkg::RANGE_DEPTH];
    logic [bfg_pkg::RANGE_DEPTH-1:0]     vld_reg;
    logic [bfg_pkg::WT_W-1:0]            data_reg;
    logic                                vq_reg;

    // valid bits stand in for a cleared table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            vq_reg  <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            vq_reg <= vld_reg[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        data_reg <= mem[raddr];
    end

    assign rdata = vq_reg ? data_reg : '0;

endmodule

// ===== design/bfg_div.sv =====
module bfg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  bfg_pkg::div_req_t  req,
    output bfg_pkg::div_rsp_t  rsp
);

    logic [bfg_pkg::WSUM_W-1:0]  rem_reg;
    logic [bfg_pkg::WSUM_W-1:0]  den_reg;
    logic [bfg_pkg::QUO_W-1:0]   low_reg;
    logic [bfg_pkg::QUO_W-1:0]   quo_reg;
    logic [bfg_pkg::DCNT_W-1:0]  cnt_reg;
    logic                        done_reg;
    logic [bfg_pkg::WSUM_W:0]    trial;
    logic                        fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, low_reg[bfg_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                cnt_reg <= bfg_pkg::DCNT_W'(bfg_pkg::QUO_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bfg_pkg::DCNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.numer[bfg_pkg::NUM_W-1:bfg_pkg::QUO_W];
            low_reg <= req.numer[bfg_pkg::QUO_W-1:0];
            den_reg <= req.denom;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? bfg_pkg::WSUM_W'(trial - {1'b0, den_reg})
                            : trial[bfg_pkg::WSUM_W-1:0];
            low_reg <= {low_reg[bfg_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[bfg_pkg::QUO_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/bfg_checker.sv =====
module bfg_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input bfg_pkg::in_item_t    s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input bfg_pkg::out_item_t   m_data
);

    // result holds until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed before transfer");

    // table writes never stall the input
    a_table_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == bfg_pkg::OP_RANGE ||
                               s_data.op == bfg_pkg::OP_SPATIAL) |=> s_ready)
        else $error("table write stalled input");

    // a new result only follows a busy period
    a_out_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without work");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bilateral_filter_gray bfg_checker u_bfg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/bilateral_filter_gray_tb.sv =====
module bilateral_filter_gray_tb;

    localparam int LIMIT = 3000000;
    localparam int N_ITEMS = 1250;
    localparam int PART_MAX = 150;
    localparam int SETTLE = 100;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    bfg_pkg::in_item_t s_data;
    logic m_valid;
    logic m_ready;
    bfg_pkg::out_item_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [bfg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bfg_pkg::CFG_W-1:0] cfg_data;

    bilateral_filter_gray dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // filter model state
    bit [7:0]  frame_px [bfg_pkg::MAX_WIDTH*bfg_pkg::MAX_HEIGHT];
    bit [16:0] range_wt [256];
    bit [16:0] space_wt [bfg_pkg::SP_DEPTH];
    int unsigned in_pos, out_pos;
    int unsigned reg_w, reg_h, reg_r;

    bfg_pkg::out_item_t pix_expected [$];
    int fails = 0;
    int cycles = 0;

    // idling controls and typed expectations
    bit pace_on;
    bit hold_long;
    bit typed_on;
    bfg_pkg::out_item_t typed_val;

    function automatic int unsigned eff_w();
        return (reg_w < 1) ? 1 : (reg_w > bfg_pkg::MAX_WIDTH) ? bfg_pkg::MAX_WIDTH : reg_w;
    endfunction

    function automatic int unsigned eff_h();
        return (reg_h < 1) ? 1 : (reg_h > bfg_pkg::MAX_HEIGHT) ? bfg_pkg::MAX_HEIGHT : reg_h;
    endfunction

    function automatic int unsigned eff_r();
        return (reg_r > bfg_pkg::MAX_RADIUS) ? bfg_pkg::MAX_RADIUS : reg_r;
    endfunction

    function automatic bit [16:0] clip_one(bit [16:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    // weighted mean for the pixel at out_pos, then advance the frame
    function automatic bfg_pkg::out_item_t filter_next(int unsigned w, int unsigned h,
                                                       int unsigned r);
        bfg_pkg::out_item_t res;
        int row, col, y, x, d2;
        bit [7:0] ctr, p;
        longint unsigned psum, wsum, wt, q;
        int unsigned total;
        total = w * h;
        row = out_pos / w;
        col = out_pos % w;
        ctr = frame_px[out_pos];
        psum = 0;
        wsum = 0;
        for (int dy = -int'(r); dy <= int'(r); dy++) begin
            for (int dx = -int'(r); dx <= int'(r); dx++) begin
                d2 = dy * dy + dx * dx;
                if (d2 <= int'(r * r)) begin
                    y = row + dy;
                    x = col + dx;
                    if (y < 0) y = 0;
                    if (y > int'(h) - 1) y = h - 1;
                    if (x < 0) x = 0;
                    if (x > int'(w) - 1) x = w - 1;
                    p = frame_px[y * w + x];
                    wt = (longint'(space_wt[d2]) *
                          longint'(range_wt[(p >= ctr) ? p - ctr : ctr - p])) >> 16;
                    psum += wt * p;
                    wsum += wt;
                end
            end
        end
        if (wsum == 0) begin
            q = ctr;
        end else begin
            q = (psum + wsum / 2) / wsum;
            if (q > 255) q = 255;
        end
        res.out_pixel = q[7:0];
        res.out_row = row[9:0];
        res.out_col = col[9:0];
        res.out_last = (out_pos == total - 1);
        out_pos++;
        if (out_pos >= total) begin
            out_pos = 0;
            in_pos = 0;
        end
        return res;
    endfunction

    // apply one accepted item; returns 1 when it yields a filtered pixel
    function automatic bit filter_step(bfg_pkg::in_item_t it, output bfg_pkg::out_item_t res);
        int unsigned w, h, r, total, lag, i;
        res = '0;
        case (it.op)
            bfg_pkg::OP_RANGE: begin
                range_wt[it.table_index] = clip_one(it.weight);
                return 0;
            end
            bfg_pkg::OP_SPATIAL: begin
                if (it.table_index < bfg_pkg::SP_DEPTH)
                    space_wt[it.table_index] = clip_one(it.weight);
                return 0;
            end
            default: ;
        endcase
        w = eff_w();
        h = eff_h();
        r = eff_r();
        total = w * h;
        lag = r * w + r;
        if (it.op == bfg_pkg::OP_PIXEL) begin
            if (in_pos >= total) return 0;
            i = in_pos;
            frame_px[i] = it.pixel;
            in_pos++;
            if (i >= lag) begin
                res = filter_next(w, h, r);
                return 1;
            end
            return 0;
        end
        if (in_pos < total || out_pos >= total) return 0;
        res = filter_next(w, h, r);
        return 1;
    endfunction

    // transfer monitor and checker
    always @(posedge aclk) begin
        bfg_pkg::out_item_t pred, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bfg_pkg::REG_IMAGE_WIDTH:  reg_w = cfg_data;
                    bfg_pkg::REG_IMAGE_HEIGHT: reg_h = cfg_data;
                    bfg_pkg::REG_RADIUS:       reg_r = cfg_data[bfg_pkg::RAD_W-1:0];
                    default: ;
                endcase
                if (cfg_index inside {bfg_pkg::REG_IMAGE_WIDTH, bfg_pkg::REG_IMAGE_HEIGHT,
                                      bfg_pkg::REG_RADIUS}) begin
                    in_pos = 0;
                    out_pos = 0;
                end
            end
            if (s_valid && s_ready) begin
                if (filter_step(s_data, pred))
                    pix_expected.push_back(typed_on ? typed_val : pred);
            end
            if (m_valid && m_ready) begin
                if (pix_expected.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    fails++;
                end else begin
                    want = pix_expected.pop_front();
                    if (m_data.out_pixel !== want.out_pixel)
                        $display("%0t: out_pixel expected %0d actual %0d",
                                 $time, want.out_pixel, m_data.out_pixel);
                    if (m_data.out_row !== want.out_row)
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, want.out_row, m_data.out_row);
                    if (m_data.out_col !== want.out_col)
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, want.out_col, m_data.out_col);
                    if (m_data.out_last !== want.out_last)
                        $display("%0t: out_last expected %0d actual %0d",
                                 $time, want.out_last, m_data.out_last);
                    if (m_data !== want) fails++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
                hold_long = 1'b0;
            end
            g = pace_on ? $urandom_range(0, 7) : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // one input transfer; called just after a falling edge
    task automatic push_item(bfg_pkg::in_item_t it);
        int g;
        g = pace_on ? $urandom_range(0, 7) : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pix_expected.size() != 0) @(negedge aclk);
    endtask

    // register write while the filter is idle
    task automatic write_reg(logic [bfg_pkg::CFG_IDX_W-1:0] idx,
                             logic [bfg_pkg::CFG_W-1:0] val);
        wait_drained();
        repeat (80) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int r);
        write_reg(bfg_pkg::REG_IMAGE_WIDTH, w[bfg_pkg::CFG_W-1:0]);
        write_reg(bfg_pkg::REG_IMAGE_HEIGHT, h[bfg_pkg::CFG_W-1:0]);
        write_reg(bfg_pkg::REG_RADIUS, bfg_pkg::CFG_W'(r));
        // unknown register index past the radius
        if ($urandom_range(0, 3) == 0)
            write_reg(bfg_pkg::CFG_IDX_W'(bfg_pkg::REG_RADIUS + 1'b1),
                      bfg_pkg::CFG_W'($urandom));
    endtask

    function automatic bfg_pkg::in_item_t mk(bfg_pkg::op_t op, bit [7:0] px, bit [7:0] idx,
                                             bit [16:0] wt);
        bfg_pkg::in_item_t it;
        it.op = op;
        it.pixel = px;
        it.table_index = idx;
        it.weight = wt;
        return it;
    endfunction

    function automatic bit [16:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 17'd65536;
            1: return 17'($urandom);
            2: return 17'd0;
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic bfg_pkg::in_item_t rand_table_write();
        if ($urandom_range(0, 1))
            return mk(bfg_pkg::OP_RANGE, 8'($urandom), 8'($urandom), rand_weight());
        return mk(bfg_pkg::OP_SPATIAL, 8'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9)),
                  rand_weight());
    endfunction

    // directed stimulus on a 2x2 frame at radius 1
    typedef struct {
        bfg_pkg::op_t       op;
        bit [7:0]           px;
        bit [7:0]           idx;
        bit [16:0]          wt;
        bit                 typed;
        bfg_pkg::out_item_t want;
    } step_row_t;

    localparam int N_ROWS = 24;
    step_row_t steps [N_ROWS] = '{
        '{bfg_pkg::OP_PIXEL,   8'd0,   8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_PIXEL,   8'd255, 8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_PIXEL,   8'd7,   8'd0,   17'd0,      1'b0, '0},
        // tables still clear: centre pixel comes back
        '{bfg_pkg::OP_PIXEL,   8'd200, 8'd0,   17'd0,      1'b1, '{8'd0,   10'd0, 10'd0, 1'b0}},
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b1, '{8'd255, 10'd0, 10'd1, 1'b0}},
        // frame full, results pending: pixel dropped
        '{bfg_pkg::OP_PIXEL,   8'd9,   8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b1, '{8'd7,   10'd1, 10'd0, 1'b0}},
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b1, '{8'd200, 10'd1, 10'd1, 1'b1}},
        // drain with nothing pending
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_RANGE,   8'd0,   8'd0,   17'd65536,  1'b0, '0},
        '{bfg_pkg::OP_RANGE,   8'd0,   8'd255, 17'h1FFFF,  1'b0, '0},
        '{bfg_pkg::OP_RANGE,   8'd0,   8'd1,   17'd40000,  1'b0, '0},
        '{bfg_pkg::OP_SPATIAL, 8'd0,   8'd0,   17'd65536,  1'b0, '0},
        '{bfg_pkg::OP_SPATIAL, 8'd0,   8'd1,   17'd32768,  1'b0, '0},
        '{bfg_pkg::OP_SPATIAL, 8'd0,   8'd2,   17'd16384,  1'b0, '0},
        // spatial index past the table is ignored
        '{bfg_pkg::OP_SPATIAL, 8'd0,   8'd200, 17'h1FFFF,  1'b0, '0},
        '{bfg_pkg::OP_PIXEL,   8'd10,  8'd0,   17'd0,      1'b0, '0},
        // drain mid-frame does nothing
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_PIXEL,   8'd11,  8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_PIXEL,   8'd10,  8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_PIXEL,   8'd255, 8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b0, '0},
        '{bfg_pkg::OP_DRAIN,   8'd0,   8'd0,   17'd0,      1'b0, '0}
    };

    // random phases: width, height, radius as written
    localparam int N_GEOM = 14;
    int geom [N_GEOM][3] = '{
        '{1, 1, 0}, '{7, 5, 3}, '{2047, 1, 0}, '{16, 6, 2}, '{1, 1, 3},
        '{0, 3, 2}, '{3, 9, 1}, '{1024, 1024, 0}, '{5, 4, 3}, '{1, 9, 2},
        '{8, 8, 2}, '{9, 1, 3}, '{1, 2047, 0}, '{4, 12, 3}
    };

    // stimulus
    initial begin
        int sent, ph, w, h, r, total, n, base;
        bit smooth;
        pace_on = 1'b0;
        hold_long = 1'b0;
        typed_on = 1'b0;
        typed_val = '0;
        range_wt = '{default: '0};
        space_wt = '{default: '0};
        in_pos = 0;
        out_pos = 0;
        reg_w = 1024;
        reg_h = 1024;
        reg_r = 1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        set_geometry(2, 2, 1);
        for (int k = 0; k < N_ROWS; k++) begin
            typed_on = steps[k].typed;
            typed_val = steps[k].want;
            push_item(mk(steps[k].op, steps[k].px, steps[k].idx, steps[k].wt));
        end
        typed_on = 1'b0;

        sent = 0;
        ph = 0;
        while (sent < N_ITEMS) begin
            w = geom[ph % N_GEOM][0];
            h = geom[ph % N_GEOM][1];
            r = geom[ph % N_GEOM][2];
            set_geometry(w, h, r);
            pace_on = (ph % 4) != 3;
            repeat ($urandom_range(2, 10)) push_item(rand_table_write());
            total = eff_w() * eff_h();
            if (total > PART_MAX) begin
                // large frame: partial, no border flush
                if (w == 1024) hold_long = 1'b1;
                for (int k = 0; k < PART_MAX; k++) begin
                    push_item(mk(bfg_pkg::OP_PIXEL, 8'($urandom), 8'($urandom),
                                 17'($urandom)));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    smooth = $urandom_range(0, 1);
                    base = $urandom_range(0, 255);
                    for (int k = 0; k < total; k++) begin
                        if ($urandom_range(0, 15) == 0)
                            push_item(mk(bfg_pkg::OP_DRAIN, 8'($urandom), 8'($urandom),
                                         17'($urandom)));
                        if ($urandom_range(0, 19) == 0) push_item(rand_table_write());
                        if (ph == 6 && k == total / 2) wait_drained();
                        n = smooth ? base + $urandom_range(0, 24) - 12 : $urandom_range(0, 255);
                        n = (n < 0) ? 0 : (n > 255) ? 255 : n;
                        push_item(mk(bfg_pkg::OP_PIXEL, 8'(n), 8'($urandom), 17'($urandom)));
                        sent++;
                    end
                    if ($urandom_range(0, 2) == 0 && in_pos >= eff_w() * eff_h())
                        push_item(mk(bfg_pkg::OP_PIXEL, 8'($urandom), 8'($urandom),
                                     17'($urandom)));
                    while (in_pos >= eff_w() * eff_h()) begin
                        if ($urandom_range(0, 9) == 0) push_item(rand_table_write());
                        push_item(mk(bfg_pkg::OP_DRAIN, 8'($urandom), 8'($urandom),
                                     17'($urandom)));
                        sent++;
                    end
                end
            end
            ph++;
        end

        wait_drained();
        repeat (SETTLE) @(negedge aclk);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
